@@ rtl/bnms_pkg.sv @@
// Shared types, widths and constants of the box suppression block.
`timescale 1ns / 1ps
`default_nettype none
package bnms_pkg;

    localparam int COORD_BITS = 20;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int SCORE_BITS = 16;
    localparam int CLASS_BITS = 8;
    localparam int THR_BITS   = 16;
    localparam int KEEP_BITS  = 7;
    localparam int DBL_BITS   = COORD_BITS + 2;
    localparam int AREA_BITS  = 2 * SIZE_BITS;
    localparam int ASUM_BITS  = AREA_BITS + 1;
    localparam int INTER_BITS = 2 * DBL_BITS;
    localparam int LHS_BITS   = INTER_BITS + THR_BITS;
    localparam int RHS_BITS   = ASUM_BITS + THR_BITS;
    localparam int CMP_BITS   = INTER_BITS + THR_BITS + 1;

    localparam int REG_IDX_BITS  = 2;
    localparam int REG_DATA_BITS = 16;
    localparam logic [REG_IDX_BITS-1:0] REG_IOU_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_MAX_KEEP      = 2'd1;
    localparam logic [THR_BITS-1:0]     THR_RESET  = 16'd29491;
    localparam logic [KEEP_BITS-1:0]    KEEP_RESET = 7'd64;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic [SIZE_BITS-1:0]         box_width;
        logic [SIZE_BITS-1:0]         box_height;
        logic [SCORE_BITS-1:0]        score;
        logic [CLASS_BITS-1:0]        class_index;
        logic                         last_box;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] kept_center_x;
        logic signed [COORD_BITS-1:0] kept_center_y;
        logic [SIZE_BITS-1:0]         kept_width;
        logic [SIZE_BITS-1:0]         kept_height;
        logic [SCORE_BITS-1:0]        kept_score;
        logic [CLASS_BITS-1:0]        kept_class;
        logic                         final_result;
        logic                         overflow;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] xc;
        logic signed [COORD_BITS-1:0] yc;
        logic [SIZE_BITS-1:0]         w;
        logic [SIZE_BITS-1:0]         h;
        logic [SCORE_BITS-1:0]        score;
        logic [CLASS_BITS-1:0]        cls;
    } box_t;

    // handoff from the sorter to the suppression engine
    typedef struct packed {
        logic [KEEP_BITS-1:0] count;
        logic                 dropped;
    } set_desc_t;

    typedef enum logic [2:0] {
        F_LOAD, F_WAIT, F_RDI, F_GETI, F_SWEEP, F_WR
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_RDA, B_GETA, B_EMIT, B_RDB, B_C0, B_C1, B_C2, B_C3, B_FLUSH
    } back_state_t;

    // overlap length of two intervals in doubled units
    function automatic logic [DBL_BITS-1:0] overlap(
        input logic signed [COORD_BITS-1:0] c1,
        input logic [SIZE_BITS-1:0]         s1,
        input logic signed [COORD_BITS-1:0] c2,
        input logic [SIZE_BITS-1:0]         s2
    );
        logic signed [DBL_BITS-1:0] lo1, hi1, lo2, hi2, lo, hi;
        lo1 = (DBL_BITS'(c1) <<< 1) - $signed(DBL_BITS'(s1));
        hi1 = (DBL_BITS'(c1) <<< 1) + $signed(DBL_BITS'(s1));
        lo2 = (DBL_BITS'(c2) <<< 1) - $signed(DBL_BITS'(s2));
        hi2 = (DBL_BITS'(c2) <<< 1) + $signed(DBL_BITS'(s2));
        lo  = (lo1 > lo2) ? lo1 : lo2;
        hi  = (hi1 < hi2) ? hi1 : hi2;
        return (hi > lo) ? DBL_BITS'(hi - lo) : '0;
    endfunction

endpackage
`default_nettype wire

@@ rtl/box_non_maximum_suppression.sv @@
// Top level of the greedy box suppression block: config, set handoff and sorted store.
// Usage:
//   Boxes enter on the push/full queue port, one per beat; the beat with last_box
//   set closes the set. Boxes past MAX_BOXES are dropped and flagged in overflow.
//   Kept boxes leave on the empty/pop queue port in descending score order, at
//   most max_keep of them, final_result set on the last one of the set.
//   Config writes (wr_en, wr_index, wr_data) take effect the next cycle.
// Flow:
//   The front loads one box per cycle. After the last box it sorts the set
//   with a rank sweep of the load store into the sorted store.
//   The back then walks the sorted store: a suppressed box is skipped; a kept one is
//   emitted and, until max_keep is reached, tested against every later unflagged box
//   of the same class, which is flagged when the overlap passes the threshold.
//   While the back works, the front already loads the next set; it sorts it once
//   the back is idle.
// Reset clears all control state; stored boxes need no clearing.
// A stalled receiver holds one result in the output register and one pending;
// the suppression walk waits at its next kept box until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module box_non_maximum_suppression import bnms_pkg::*; #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    output logic                          full,
    input  wire in_item_t                 box,
    output logic                          empty,
    input  wire logic                     pop,
    output out_item_t                     kept,
    input  wire logic                     wr_en,
    input  wire logic [REG_IDX_BITS-1:0]  wr_index,
    input  wire logic [REG_DATA_BITS-1:0] wr_data
);

    localparam int AW = $clog2(MAX_BOXES);

    logic [THR_BITS-1:0]  thr_reg;
    logic [KEEP_BITS-1:0] keep_reg;
    set_desc_t            desc_reg;
    logic                 desc_valid_reg;

    logic          desc_push, desc_pop, back_idle, srt_we;
    set_desc_t     desc_new;
    logic [AW-1:0] srt_waddr, srt_raddr;
    box_t          srt_wdata, srt_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            keep_reg       <= KEEP_RESET;
            desc_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && (wr_index == REG_IOU_THRESHOLD))
            begin
                thr_reg <= wr_data[THR_BITS-1:0];
            end
            if (wr_en && (wr_index == REG_MAX_KEEP))
            begin
                keep_reg <= wr_data[KEEP_BITS-1:0];
            end
            if (desc_push)
            begin
                desc_valid_reg <= 1'b1;
            end
            else if (desc_pop)
            begin
                desc_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_push)
        begin
            desc_reg <= desc_new;
        end
    end

    bnms_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .box       (box),
        .desc_busy (desc_valid_reg),
        .back_idle (back_idle),
        .desc_push (desc_push),
        .desc      (desc_new),
        .srt_we    (srt_we),
        .srt_waddr (srt_waddr),
        .srt_wdata (srt_wdata)
    );

    bnms_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_sorted_ram (
        .clk   (clk),
        .we    (srt_we),
        .waddr (srt_waddr),
        .wdata (srt_wdata),
        .raddr (srt_raddr),
        .rdata (srt_rdata)
    );

    bnms_back #(.MAX_BOXES(MAX_BOXES)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .desc_valid    (desc_valid_reg),
        .desc          (desc_reg),
        .desc_pop      (desc_pop),
        .idle          (back_idle),
        .iou_threshold (thr_reg),
        .max_keep      (keep_reg),
        .srt_raddr     (srt_raddr),
        .srt_rdata     (srt_rdata),
        .empty         (empty),
        .pop           (pop),
        .kept          (kept)
    );

endmodule
`default_nettype wire

@@ rtl/bnms_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/bnms_front.sv @@
// Front end: loads one set of boxes and writes it in score order to the sorted store.
`timescale 1ns / 1ps
`default_nettype none
module bnms_front import bnms_pkg::*; #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire in_item_t                     box,
    input  wire logic                         desc_busy,
    input  wire logic                         back_idle,
    output logic                              desc_push,
    output set_desc_t                         desc,
    output logic                              srt_we,
    output logic [$clog2(MAX_BOXES)-1:0]      srt_waddr,
    output box_t                              srt_wdata
);

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    front_state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic          dropped_reg;
    logic [AW-1:0] i_reg, j_reg, jd_reg, rank_reg;
    box_t          boxi_reg;

    logic          accept, room, load_we, jd_last, i_last, ahead;
    logic [AW-1:0] raddr;
    box_t          wbox, rbox;

    assign accept  = push && !full;
    assign room    = count_reg < CW'(MAX_BOXES);
    assign load_we = accept && room;
    assign jd_last = CW'(jd_reg) == count_reg - CW'(1);
    assign i_last  = CW'(i_reg) == count_reg - CW'(1);
    // stable descending order: earlier arrivals win ties
    assign ahead   = (rbox.score > boxi_reg.score)
                     || ((rbox.score == boxi_reg.score) && (jd_reg < i_reg));

    always_comb
    begin
        wbox.xc    = box.center_x;
        wbox.yc    = box.center_y;
        wbox.w     = box.box_width;
        wbox.h     = box.box_height;
        wbox.score = box.score;
        wbox.cls   = box.class_index;
    end

    bnms_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_BOXES)) u_load_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wbox),
        .raddr (raddr),
        .rdata (rbox)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_LOAD:  if (accept && box.last_box) state_next = F_WAIT;
            F_WAIT:  if (!desc_busy && back_idle) state_next = F_RDI;
            F_RDI:   state_next = F_GETI;
            F_GETI:  state_next = F_SWEEP;
            F_SWEEP: if (jd_last) state_next = F_WR;
            F_WR:    state_next = i_last ? F_LOAD : F_RDI;
            default: state_next = F_LOAD;
        endcase
    end

    always_comb
    begin
        full      = state_reg != F_LOAD;
        srt_we    = state_reg == F_WR;
        srt_waddr = rank_reg;
        srt_wdata = boxi_reg;
        desc_push = (state_reg == F_WR) && i_last;
        desc.count   = KEEP_BITS'(count_reg);
        desc.dropped = dropped_reg;
        case (state_reg)
            F_GETI:  raddr = '0;
            F_SWEEP: raddr = j_reg;
            default: raddr = i_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            i_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                F_LOAD:
                begin
                    if (accept)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                    end
                    i_reg <= '0;
                end
                F_WR:
                begin
                    if (i_last)
                    begin
                        count_reg   <= '0;
                        dropped_reg <= 1'b0;
                    end
                    i_reg <= i_reg + AW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_GETI:
            begin
                boxi_reg <= rbox;
                rank_reg <= '0;
                jd_reg   <= '0;
                j_reg    <= AW'(1);
            end
            F_SWEEP:
            begin
                if (ahead)
                begin
                    rank_reg <= rank_reg + AW'(1);
                end
                jd_reg <= j_reg;
                j_reg  <= j_reg + AW'(1);
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/bnms_back.sv @@
// Back end: greedy suppression walk over the sorted store and result output register.
`timescale 1ns / 1ps
`default_nettype none
module bnms_back import bnms_pkg::*; #(
    parameter int MAX_BOXES = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     desc_valid,
    input  wire set_desc_t                desc,
    output logic                          desc_pop,
    output logic                          idle,
    input  wire logic [THR_BITS-1:0]      iou_threshold,
    input  wire logic [KEEP_BITS-1:0]     max_keep,
    output logic [$clog2(MAX_BOXES)-1:0]  srt_raddr,
    input  wire box_t                     srt_rdata,
    output logic                          empty,
    input  wire logic                     pop,
    output out_item_t                     kept
);

    localparam int AW = $clog2(MAX_BOXES);

    back_state_t state_reg, state_next;
    logic [KEEP_BITS-1:0] n_reg, emitted_reg;
    logic                 dropped_reg;
    logic [AW-1:0]        i_reg, j_reg;
    logic [MAX_BOXES-1:0] flags_reg;
    box_t                 a_reg, pend_reg;
    logic                 pend_valid_reg, out_valid_reg;
    out_item_t            out_reg;
    logic [AREA_BITS-1:0]  area_a_reg, area_b_reg;
    logic [DBL_BITS-1:0]   iw_reg, ih_reg;
    logic [INTER_BITS-1:0] inter_reg;
    logic [ASUM_BITS-1:0]  asum_reg;
    logic [LHS_BITS-1:0]   lhsp_reg;
    logic [RHS_BITS-1:0]   rhsp_reg;

    logic [KEEP_BITS-1:0] limit;
    logic out_free, i_last, j_last, emit_ok, skip_b, hit;
    logic [CMP_BITS-1:0] lhs, rhs;

    assign limit    = (max_keep > KEEP_BITS'(MAX_BOXES)) ? KEEP_BITS'(MAX_BOXES) : max_keep;
    assign out_free = !out_valid_reg || pop;
    assign i_last   = KEEP_BITS'(i_reg) + KEEP_BITS'(1) == n_reg;
    assign j_last   = KEEP_BITS'(j_reg) + KEEP_BITS'(1) == n_reg;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign skip_b   = flags_reg[j_reg] || (srt_rdata.cls != a_reg.cls);
    // inter * (65536 + thr) against thr * 4 * (area_a + area_b)
    assign lhs      = CMP_BITS'({inter_reg, 16'b0}) + CMP_BITS'(lhsp_reg);
    assign rhs      = CMP_BITS'({rhsp_reg, 2'b0});
    assign hit      = (asum_reg != '0) && (lhs > rhs);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (desc_valid) state_next = (limit == '0) ? B_FLUSH : B_RDA;
            B_RDA:   state_next = B_GETA;
            B_GETA:
            begin
                if (!flags_reg[i_reg]) state_next = B_EMIT;
                else state_next = i_last ? B_FLUSH : B_RDA;
            end
            B_EMIT:
            begin
                if (emit_ok)
                begin
                    if ((emitted_reg + KEEP_BITS'(1) == limit) || i_last)
                        state_next = B_FLUSH;
                    else
                        state_next = B_RDB;
                end
            end
            B_RDB:   state_next = B_C0;
            B_C0:
            begin
                if (!skip_b) state_next = B_C1;
                else state_next = j_last ? B_RDA : B_RDB;
            end
            B_C1:    state_next = B_C2;
            B_C2:    state_next = B_C3;
            B_C3:    state_next = j_last ? B_RDA : B_RDB;
            B_FLUSH: if (!pend_valid_reg || out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        desc_pop  = (state_reg == B_IDLE) && desc_valid;
        idle      = state_reg == B_IDLE;
        srt_raddr = (state_reg == B_RDA) ? i_reg : j_reg;
        empty     = !out_valid_reg;
        kept      = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            flags_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (desc_valid)
                    begin
                        flags_reg <= '0;
                    end
                end
                B_EMIT:
                begin
                    if (emit_ok)
                    begin
                        pend_valid_reg <= 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                B_C3:
                begin
                    if (hit)
                    begin
                        flags_reg[j_reg] <= 1'b1;
                    end
                end
                B_FLUSH:
                begin
                    if (pend_valid_reg && out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        out_valid_reg  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                n_reg       <= desc.count;
                dropped_reg <= desc.dropped;
                i_reg       <= '0;
                emitted_reg <= '0;
            end
            B_GETA:
            begin
                a_reg      <= srt_rdata;
                area_a_reg <= srt_rdata.w * srt_rdata.h;
                if (flags_reg[i_reg])
                begin
                    i_reg <= i_reg + AW'(1);
                end
            end
            B_EMIT:
            begin
                if (emit_ok)
                begin
                    pend_reg    <= a_reg;
                    emitted_reg <= emitted_reg + KEEP_BITS'(1);
                    j_reg       <= i_reg + AW'(1);
                    if (pend_valid_reg)
                    begin
                        out_reg <= '{pend_reg.xc, pend_reg.yc, pend_reg.w, pend_reg.h,
                                     pend_reg.score, pend_reg.cls, 1'b0, dropped_reg};
                    end
                end
            end
            B_C0:
            begin
                iw_reg     <= overlap(a_reg.xc, a_reg.w, srt_rdata.xc, srt_rdata.w);
                ih_reg     <= overlap(a_reg.yc, a_reg.h, srt_rdata.yc, srt_rdata.h);
                area_b_reg <= srt_rdata.w * srt_rdata.h;
                if (skip_b)
                begin
                    if (j_last) i_reg <= i_reg + AW'(1);
                    else j_reg <= j_reg + AW'(1);
                end
            end
            B_C1:
            begin
                inter_reg <= iw_reg * ih_reg;
                asum_reg  <= ASUM_BITS'(area_a_reg) + ASUM_BITS'(area_b_reg);
            end
            B_C2:
            begin
                lhsp_reg <= inter_reg * iou_threshold;
                rhsp_reg <= asum_reg * iou_threshold;
            end
            B_C3:
            begin
                if (j_last) i_reg <= i_reg + AW'(1);
                else j_reg <= j_reg + AW'(1);
            end
            B_FLUSH:
            begin
                if (pend_valid_reg && out_free)
                begin
                    out_reg <= '{pend_reg.xc, pend_reg.yc, pend_reg.w, pend_reg.h,
                                 pend_reg.score, pend_reg.cls, 1'b1, dropped_reg};
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ sim/box_non_maximum_suppression_test.sv @@
// Self-checking testbench for the greedy box suppression block.
`timescale 1ns / 1ps
`default_nettype none
module box_non_maximum_suppression_test;
    import bnms_pkg::*;

    localparam int DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    in_item_t box;
    logic empty;
    logic pop;
    out_item_t kept;
    logic wr_en;
    logic [REG_IDX_BITS-1:0] wr_index;
    logic [REG_DATA_BITS-1:0] wr_data;

    box_non_maximum_suppression dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .box(box),
        .empty(empty), .pop(pop), .kept(kept),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    // predictor state
    box_t set_store[DEPTH];
    int unsigned set_count;
    bit set_dropped;
    logic [THR_BITS-1:0] thr_q;
    logic [KEEP_BITS-1:0] keep_q;
    out_item_t kept_queue[$];

    int unsigned errors;
    int unsigned boxes_sent;
    int unsigned kept_seen;
    int unsigned sets_closed;
    int unsigned idle_cycles;
    bit rx_hold;
    bit rx_calm;
    bit tx_calm;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [127:0] got,
                                   input logic [127:0] want);
        errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic logic signed [DBL_BITS:0] dbl_edge(
        input logic signed [COORD_BITS-1:0] c, input logic [SIZE_BITS-1:0] s,
        input bit upper);
        logic signed [DBL_BITS:0] cc;
        logic signed [DBL_BITS:0] ss;
        cc = c;
        ss = $signed({1'b0, s});
        return upper ? (cc <<< 1) + ss : (cc <<< 1) - ss;
    endfunction

    function automatic logic [DBL_BITS:0] span_overlap(
        input logic signed [COORD_BITS-1:0] c1, input logic [SIZE_BITS-1:0] s1,
        input logic signed [COORD_BITS-1:0] c2, input logic [SIZE_BITS-1:0] s2);
        logic signed [DBL_BITS:0] l1, h1, l2, h2, lo, hi;
        l1 = dbl_edge(c1, s1, 0);
        h1 = dbl_edge(c1, s1, 1);
        l2 = dbl_edge(c2, s2, 0);
        h2 = dbl_edge(c2, s2, 1);
        lo = (l1 > l2) ? l1 : l2;
        hi = (h1 < h2) ? h1 : h2;
        return (hi > lo) ? hi - lo : '0;
    endfunction

    function automatic bit too_close(input box_t a, input box_t b);
        logic [127:0] area_a, area_b, iw, ih, inter, lhs, rhs;
        area_a = 128'(a.w) * 128'(a.h) * 4;
        area_b = 128'(b.w) * 128'(b.h) * 4;
        if (area_a == 0 && area_b == 0)
            return 1'b0;
        iw = span_overlap(a.xc, a.w, b.xc, b.w);
        ih = span_overlap(a.yc, a.h, b.yc, b.h);
        inter = iw * ih;
        lhs = inter * (128'd65536 + 128'(thr_q));
        rhs = 128'(thr_q) * (area_a + area_b);
        return lhs > rhs;
    endfunction

    // store a box; on the closing beat sort, suppress and queue the kept boxes
    task automatic predict_kept(input in_item_t b);
        int order[DEPTH];
        bit gone[DEPTH];
        int j, v, lim, emitted, last_idx;
        out_item_t o;
        if (set_count < DEPTH)
        begin
            set_store[set_count] = '{b.center_x, b.center_y, b.box_width,
                                     b.box_height, b.score, b.class_index};
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (!b.last_box)
            return;
        sets_closed++;
        for (int i = 0; i < set_count; i++)
        begin
            v = i;
            j = i;
            while (j > 0 && set_store[order[j-1]].score < set_store[v].score)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
            gone[i] = 1'b0;
        end
        lim = (keep_q > DEPTH) ? DEPTH : keep_q;
        emitted = 0;
        last_idx = -1;
        for (int i = 0; i < set_count; i++)
        begin
            if (gone[order[i]])
                continue;
            if (emitted < lim)
            begin
                o.kept_center_x = set_store[order[i]].xc;
                o.kept_center_y = set_store[order[i]].yc;
                o.kept_width = set_store[order[i]].w;
                o.kept_height = set_store[order[i]].h;
                o.kept_score = set_store[order[i]].score;
                o.kept_class = set_store[order[i]].cls;
                o.final_result = 1'b0;
                o.overflow = set_dropped;
                kept_queue = {kept_queue, o};
                last_idx = kept_queue.size() - 1;
                emitted++;
            end
            for (int k = i + 1; k < set_count; k++)
                if (!gone[order[k]] && set_store[order[i]].cls == set_store[order[k]].cls
                    && too_close(set_store[order[i]], set_store[order[k]]))
                    gone[order[k]] = 1'b1;
        end
        if (last_idx >= 0)
            kept_queue[last_idx].final_result = 1'b1;
        set_count = 0;
        set_dropped = 1'b0;
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= !rx_hold && (rx_calm || $urandom_range(99) >= 15);
    end

    // check each accepted result beat; watchdog on stalled progress
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if ((pop && !empty) || (push && !full))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (pop && !empty)
            begin
                kept_seen++;
                if (kept_queue.size() == 0)
                    report_mismatch("unexpected beat", kept, '0);
                else
                begin
                    want = kept_queue.pop_front();
                    if (kept.kept_center_x !== want.kept_center_x)
                        report_mismatch("center x", kept.kept_center_x, want.kept_center_x);
                    if (kept.kept_center_y !== want.kept_center_y)
                        report_mismatch("center y", kept.kept_center_y, want.kept_center_y);
                    if (kept.kept_width !== want.kept_width)
                        report_mismatch("width", kept.kept_width, want.kept_width);
                    if (kept.kept_height !== want.kept_height)
                        report_mismatch("height", kept.kept_height, want.kept_height);
                    if (kept.kept_score !== want.kept_score)
                        report_mismatch("score", kept.kept_score, want.kept_score);
                    if (kept.kept_class !== want.kept_class)
                        report_mismatch("class", kept.kept_class, want.kept_class);
                    if (kept.final_result !== want.final_result)
                        report_mismatch("final", kept.final_result, want.final_result);
                    if (kept.overflow !== want.overflow)
                        report_mismatch("overflow", kept.overflow, want.overflow);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d beats pending", kept_queue.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // offer one box until it is taken; random gaps unless calm
    task automatic send_box(input in_item_t b);
        while (!tx_calm && $urandom_range(99) < 15)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        box <= b;
        do
            @(posedge clk);
        while (full);
        predict_kept(b);
        boxes_sent++;
    endtask

    // drop push, then wait until every expected beat has come
    task automatic drain_and_settle();
        push <= 1'b0;
        while (kept_queue.size() != 0)
            @(posedge clk);
        repeat (20000) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [REG_DATA_BITS-1:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == REG_IOU_THRESHOLD)
            thr_q = val[THR_BITS-1:0];
        else if (idx == REG_MAX_KEEP)
            keep_q = val[KEEP_BITS-1:0];
        @(posedge clk);
    endtask

    function automatic in_item_t rand_box(input bit last, input int cls_span,
                                          input bit wide_range);
        in_item_t b;
        if (wide_range)
        begin
            b.center_x = 20'($urandom);
            b.center_y = 20'($urandom);
            b.box_width = 19'($urandom);
            b.box_height = 19'($urandom);
        end
        else
        begin
            b.center_x = $signed(20'($urandom_range(4000))) - 20'sd2000;
            b.center_y = $signed(20'($urandom_range(4000))) - 20'sd2000;
            b.box_width = 19'($urandom_range(3000));
            b.box_height = 19'($urandom_range(3000));
        end
        b.score = ($urandom_range(3) == 0) ? 16'($urandom_range(3) * 16384) : 16'($urandom);
        b.class_index = 8'($urandom_range(cls_span));
        b.last_box = last;
        return b;
    endfunction

    task automatic send_set(input int n, input int cls_span, input bit wide_range);
        for (int i = 0; i < n; i++)
            send_box(rand_box(i == n - 1, cls_span, wide_range));
    endtask

    in_item_t directed[19];
    int n_set;

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        box = '0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        rx_hold = 1'b0;
        rx_calm = 1'b0;
        tx_calm = 1'b0;
        errors = 0;
        boxes_sent = 0;
        kept_seen = 0;
        sets_closed = 0;
        idle_cycles = 0;
        set_count = 0;
        set_dropped = 1'b0;
        thr_q = THR_RESET;
        keep_q = KEEP_RESET;
        // center x, center y, width, height, score, class, last
        directed = '{
            '{20'sh7FFFF, 20'sh80000, 19'h7FFFF, 19'h7FFFF, 16'hFFFF, 8'hFF, 1'b1},
            '{20'sh80000, 20'sh7FFFF, 19'h00000, 19'h00000, 16'h0000, 8'h00, 1'b1},
            '{20'sh00000, 20'sh00000, 19'h00400, 19'h00400, 16'h8000, 8'h01, 1'b0},
            '{20'sh00010, 20'sh00010, 19'h00400, 19'h00400, 16'h9000, 8'h01, 1'b0},
            '{20'sh00010, 20'sh00010, 19'h00400, 19'h00400, 16'h9000, 8'h02, 1'b0},
            '{20'sh40000, 20'sh40000, 19'h00100, 19'h00100, 16'h8000, 8'h01, 1'b0},
            '{20'sh00000, 20'sh00000, 19'h00000, 19'h00000, 16'h8000, 8'h01, 1'b0},
            '{20'sh00000, 20'sh00000, 19'h00000, 19'h00000, 16'h7000, 8'h01, 1'b1},
            '{20'sh00000, 20'sh00000, 19'h00800, 19'h00800, 16'h0001, 8'h05, 1'b0},
            '{20'sh00000, 20'sh00000, 19'h00800, 19'h00800, 16'h0001, 8'h05, 1'b1},
            '{20'sh7FFFF, 20'sh7FFFF, 19'h7FFFF, 19'h7FFFF, 16'h4000, 8'h07, 1'b0},
            '{20'sh7FFF0, 20'sh7FFF0, 19'h7FFFF, 19'h7FFFF, 16'h5000, 8'h07, 1'b0},
            '{20'sh80000, 20'sh80000, 19'h7FFFF, 19'h40000, 16'h3000, 8'h07, 1'b1},
            '{20'sh00000, 20'sh00000, 19'h00200, 19'h00200, 16'hA000, 8'h09, 1'b0},
            '{20'sh00000, 20'sh00000, 19'h00200, 19'h00200, 16'hA000, 8'h09, 1'b0},
            '{20'sh00100, 20'sh00000, 19'h00200, 19'h00200, 16'hB000, 8'h09, 1'b1},
            '{20'sh12345, 20'sh54321, 19'h2AAAA, 19'h55555, 16'h5555, 8'hAA, 1'b1},
            '{20'shAAAAA, 20'sh55555, 19'h55555, 19'h2AAAA, 16'hAAAA, 8'h55, 1'b1},
            '{20'sh00000, 20'sh00000, 19'h00300, 19'h00300, 16'h0000, 8'h00, 1'b1}
        };
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: first two rows are lone sets whose kept beat is the box itself
        foreach (directed[i])
            send_box(directed[i]);
        drain_and_settle();

        // threshold zero suppresses any overlapping pair; max_keep at one
        write_reg(REG_IOU_THRESHOLD, 16'd0);
        write_reg(REG_MAX_KEEP, 16'd1);
        write_reg(REG_SPARE, 16'hFFFF);
        for (int s = 0; s < 4; s++)
            send_set($urandom_range(2, 8), 2, 1'b0);
        drain_and_settle();

        // max_keep zero empties every set; threshold at the top
        write_reg(REG_IOU_THRESHOLD, 16'hFFFF);
        write_reg(REG_MAX_KEEP, 16'd0);
        send_set(5, 1, 1'b0);
        drain_and_settle();

        // overflow: more boxes than the store holds, with max_keep beyond depth
        write_reg(REG_MAX_KEEP, 16'd127);
        write_reg(REG_IOU_THRESHOLD, 16'hFFFF);
        send_set(DEPTH + 3, 255, 1'b1);
        drain_and_settle();

        // long receiver hold-off while the sender keeps pushing
        write_reg(REG_IOU_THRESHOLD, 16'd29491);
        write_reg(REG_MAX_KEEP, 16'd64);
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(posedge clk);
                rx_hold = 1'b0;
            end
            begin
                tx_calm = 1'b1;
                for (int s = 0; s < 6; s++)
                    send_set($urandom_range(1, 6), 3, 1'b0);
                tx_calm = 1'b0;
                drain_and_settle();
            end
        join

        // random sets, small and clustered mostly; one calm stretch
        while (boxes_sent < 330)
        begin
            if (sets_closed % 7 == 3)
            begin
                write_reg(REG_IOU_THRESHOLD, 16'($urandom));
                write_reg(REG_MAX_KEEP, 16'($urandom_range(1, 64)));
            end
            rx_calm = (sets_closed >= 20 && sets_closed < 26);
            tx_calm = rx_calm;
            n_set = ($urandom_range(9) == 0) ? int'($urandom_range(20, 40))
                                             : int'($urandom_range(1, 10));
            send_set(n_set, int'($urandom_range(3)), $urandom_range(4) == 0);
            drain_and_settle();
        end
        rx_calm = 1'b0;
        tx_calm = 1'b0;

        repeat (2000) @(posedge clk);
        $display("sent %0d boxes in %0d sets, checked %0d kept boxes", boxes_sent,
                 sets_closed, kept_seen);
        $display("covered thresholds 0 to max, max_keep 0 to 127, overflow and stalls");
        if (errors == 0 && kept_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
